>>> sv/dpfc_pkg.sv
// Package for the distinct prime factor counter: widths, constants and the
// request/response structs between the control path and the seen-prime store.
// No dependencies.
package dpfc_pkg;

    localparam int VALUE_BITS  = 10;
    localparam int SEEN_DEPTH  = 1 << VALUE_BITS;
    localparam int COUNT_BITS  = 8;
    localparam int DCNT_BITS   = $clog2(VALUE_BITS + 1);
    localparam int SQ_BITS     = 2 * VALUE_BITS;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX     = '1;
    localparam logic [VALUE_BITS-1:0] FIRST_DIVISOR = VALUE_BITS'(2);
    localparam logic [SQ_BITS-1:0]    FIRST_SQUARE  = SQ_BITS'(4);

    // Control path -> seen-prime store
    typedef struct packed {
        logic                  mark;   // test-and-set the bit at addr
        logic                  clear;  // start a clearing sweep
        logic [VALUE_BITS-1:0] addr;
    } t_seen_req;

    // Seen-prime store -> control path
    typedef struct packed {
        logic done;      // mark finished this cycle
        logic fresh;     // the marked bit was clear before
        logic clearing;  // sweep in progress
    } t_seen_rsp;

endpackage

>>> sv/dpfc_divider.sv
// Bit-serial restoring divider: one quotient bit per cycle, VALUE_BITS bits in all.
// Depends on dpfc_pkg.
module dpfc_divider (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [dpfc_pkg::VALUE_BITS-1:0] i_dividend,
    input  logic [dpfc_pkg::VALUE_BITS-1:0] i_divisor,
    output logic                           o_done,
    output logic [dpfc_pkg::VALUE_BITS-1:0] o_quot,
    output logic [dpfc_pkg::VALUE_BITS-1:0] o_rem
);

    logic [dpfc_pkg::VALUE_BITS-1:0] r_dq, n_dq;
    logic [dpfc_pkg::VALUE_BITS-1:0] r_pr, n_pr;
    logic [dpfc_pkg::VALUE_BITS-1:0] r_dsr, n_dsr;
    logic [dpfc_pkg::DCNT_BITS-1:0]  r_cnt, n_cnt;
    logic                            r_done, n_done;

    logic [dpfc_pkg::VALUE_BITS:0] w_trial;
    logic [dpfc_pkg::VALUE_BITS:0] w_diff;
    logic                          w_ge;

    // shift in the next dividend bit, subtract if it fits
    assign w_trial = {r_pr, r_dq[dpfc_pkg::VALUE_BITS-1]};
    assign w_ge    = (w_trial >= {1'b0, r_dsr});
    assign w_diff  = w_trial - {1'b0, r_dsr};

    always_comb begin
        n_dq   = r_dq;
        n_pr   = r_pr;
        n_dsr  = r_dsr;
        n_cnt  = r_cnt;
        n_done = 1'b0;
        if (i_start) begin
            n_dq  = i_dividend;
            n_pr  = '0;
            n_dsr = i_divisor;
            n_cnt = dpfc_pkg::DCNT_BITS'(dpfc_pkg::VALUE_BITS);
        end else if (r_cnt != '0) begin
            n_pr   = w_ge ? w_diff[dpfc_pkg::VALUE_BITS-1:0]
                          : w_trial[dpfc_pkg::VALUE_BITS-1:0];
            n_dq   = {r_dq[dpfc_pkg::VALUE_BITS-2:0], w_ge};
            n_cnt  = r_cnt - 1'b1;
            n_done = (r_cnt == dpfc_pkg::DCNT_BITS'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
        r_dq  <= n_dq;
        r_pr  <= n_pr;
        r_dsr <= n_dsr;
    end

    assign o_done = r_done;
    assign o_quot = r_dq;
    assign o_rem  = r_pr;

endmodule

>>> sv/dpfc_seen.sv
// Seen-prime bitmap: one-bit memory with test-and-set marking and a clearing
// sweep (one entry a cycle) after reset and on request. Depends on dpfc_pkg.
module dpfc_seen (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  dpfc_pkg::t_seen_req   i_req,
    output dpfc_pkg::t_seen_rsp   o_rsp
);

    logic mem [dpfc_pkg::SEEN_DEPTH];

    logic                            r_rd;
    logic [dpfc_pkg::VALUE_BITS-1:0] r_addr;
    logic                            r_pend, n_pend;
    logic                            r_clr, n_clr;
    logic [dpfc_pkg::VALUE_BITS-1:0] r_clr_addr, n_clr_addr;

    always_comb begin
        n_pend     = i_req.mark;
        n_clr      = r_clr;
        n_clr_addr = r_clr_addr;
        if (r_clr) begin
            n_clr_addr = r_clr_addr + 1'b1;
            if (r_clr_addr == '1) begin
                n_clr = 1'b0;
            end
        end else if (i_req.clear) begin
            n_clr      = 1'b1;
            n_clr_addr = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend     <= 1'b0;
            r_clr      <= 1'b1;
            r_clr_addr <= '0;
        end else begin
            r_pend     <= n_pend;
            r_clr      <= n_clr;
            r_clr_addr <= n_clr_addr;
        end
        r_addr <= i_req.addr;
    end

    // registered read, single write port shared by sweep and mark
    always_ff @(posedge i_clk) begin
        r_rd <= mem[i_req.addr];
        if (r_clr) begin
            mem[r_clr_addr] <= 1'b0;
        end else if (r_pend && !r_rd) begin
            mem[r_addr] <= 1'b1;
        end
    end

    assign o_rsp.done     = r_pend;
    assign o_rsp.fresh    = ~r_rd;
    assign o_rsp.clearing = r_clr;

endmodule

>>> sv/distinct_prime_factor_count_top.sv
// Top level of the distinct prime factor counter: trial-division sequencer,
// distinct counter and result register. Depends on dpfc_pkg, dpfc_divider
// and dpfc_seen.
//
// Usage:
//   Input channel: a beat (i_value, i_last) is taken at a rising edge with
//   start high and busy low. One value is factored at a time; busy stays high
//   until the value is done.
//   Result channel: after a beat with i_last set, o_prime_count holds the
//   number of distinct primes seen in the set, marked by o_valid for exactly
//   one cycle, in the cycle after the value's finish step. The receiver
//   cannot stall; the result is simply presented.
//   Steps per value: trial divisors run from 2 while d*d <= remainder; each
//   trial is one check step plus one bit-serial division in the shared
//   divider, plus one more division for every repeat of a found factor, plus
//   one bitmap mark per prime found (test-and-set reads in the request cycle,
//   writes in the next). Values 0 and 1 go straight to the finish step.
//   After a beat with i_last the bitmap is swept clear, one entry a cycle,
//   all 2**VALUE_BITS entries, with busy high.
//   Reset (i_rst_n low, synchronous): the counter is zeroed and the same
//   clearing sweep runs; busy is high until it ends.
module distinct_prime_factor_count_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [dpfc_pkg::VALUE_BITS-1:0]  i_value,
    input  logic                             i_last,
    output logic                             o_valid,
    output logic [dpfc_pkg::COUNT_BITS-1:0]  o_prime_count
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_CHECK  = 5'b00010,
        S_DIV    = 5'b00100,
        S_MARK   = 5'b01000,
        S_FINISH = 5'b10000
    } t_state;

    t_state                          r_state, n_state;
    logic [dpfc_pkg::VALUE_BITS-1:0] r_rem, n_rem;
    logic [dpfc_pkg::VALUE_BITS-1:0] r_div, n_div;
    logic [dpfc_pkg::SQ_BITS-1:0]    r_sq, n_sq;     // r_div squared
    logic                            r_last, n_last;
    logic                            r_found, n_found; // r_div already marked
    logic                            r_tail, n_tail;   // marking the leftover prime
    logic [dpfc_pkg::COUNT_BITS-1:0] r_count, n_count;
    logic                            r_valid, n_valid;
    logic [dpfc_pkg::COUNT_BITS-1:0] r_out, n_out;

    logic                            w_accept;
    logic                            w_div_start;
    logic [dpfc_pkg::VALUE_BITS-1:0] w_dividend;
    logic                            w_div_done;
    logic [dpfc_pkg::VALUE_BITS-1:0] w_quot;
    logic [dpfc_pkg::VALUE_BITS-1:0] w_drem;
    dpfc_pkg::t_seen_req             w_req;
    dpfc_pkg::t_seen_rsp             w_rsp;

    assign busy     = (r_state != S_IDLE) || w_rsp.clearing;
    assign w_accept = start && !busy;

    // a repeat division uses the fresh quotient straight from the divider
    assign w_dividend = (r_state == S_DIV) ? w_quot : r_rem;

    always_comb begin
        n_state     = r_state;
        n_rem       = r_rem;
        n_div       = r_div;
        n_sq        = r_sq;
        n_last      = r_last;
        n_found     = r_found;
        n_tail      = r_tail;
        n_count     = r_count;
        n_valid     = 1'b0;
        n_out       = r_out;
        w_div_start = 1'b0;
        w_req       = '0;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_rem   = i_value;
                    n_div   = dpfc_pkg::FIRST_DIVISOR;
                    n_sq    = dpfc_pkg::FIRST_SQUARE;
                    n_last  = i_last;
                    n_found = 1'b0;
                    n_state = (i_value < dpfc_pkg::VALUE_BITS'(2)) ? S_FINISH : S_CHECK;
                end
            end
            S_CHECK: begin
                if (r_sq <= {{dpfc_pkg::VALUE_BITS{1'b0}}, r_rem}) begin
                    w_div_start = 1'b1;
                    n_state     = S_DIV;
                end else if (r_rem > dpfc_pkg::VALUE_BITS'(1)) begin
                    // leftover above one is itself prime
                    w_req.mark = 1'b1;
                    w_req.addr = r_rem;
                    n_tail     = 1'b1;
                    n_state    = S_MARK;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    if (w_drem == '0) begin
                        n_rem = w_quot;
                        if (!r_found) begin
                            n_found    = 1'b1;
                            w_req.mark = 1'b1;
                            w_req.addr = r_div;
                            n_tail     = 1'b0;
                            n_state    = S_MARK;
                        end else begin
                            w_div_start = 1'b1;
                        end
                    end else begin
                        // (d+1)^2 = d^2 + 2d + 1
                        n_sq    = r_sq
                                  + {{(dpfc_pkg::VALUE_BITS-1){1'b0}}, r_div, 1'b0}
                                  + dpfc_pkg::SQ_BITS'(1);
                        n_div   = r_div + 1'b1;
                        n_found = 1'b0;
                        n_state = S_CHECK;
                    end
                end
            end
            S_MARK: begin
                if (w_rsp.done) begin
                    if (w_rsp.fresh && (r_count != dpfc_pkg::COUNT_MAX)) begin
                        n_count = r_count + 1'b1;
                    end
                    if (r_tail) begin
                        n_state = S_FINISH;
                    end else begin
                        w_div_start = 1'b1;
                        n_state     = S_DIV;
                    end
                end
            end
            S_FINISH: begin
                if (r_last) begin
                    n_valid     = 1'b1;
                    n_out       = r_count;
                    n_count     = '0;
                    w_req.clear = 1'b1;
                end
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
            r_found <= 1'b0;
            r_tail  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
            r_found <= n_found;
            r_tail  <= n_tail;
        end
        r_rem  <= n_rem;
        r_div  <= n_div;
        r_sq   <= n_sq;
        r_last <= n_last;
        r_out  <= n_out;
    end

    dpfc_divider u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (r_div),
        .o_done     (w_div_done),
        .o_quot     (w_quot),
        .o_rem      (w_drem)
    );

    dpfc_seen u_seen (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    assign o_valid       = r_valid;
    assign o_prime_count = r_out;

endmodule
